FILE: rtl/core/vfs_pkg.sv
`default_nettype none

package vfs_pkg;

  // Command codes carried in the cmd field
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_SET        = 3'd1;
  localparam logic [2:0] OP_FIRE       = 3'd2;
  localparam logic [2:0] OP_ABORT      = 3'd3;
  localparam logic [2:0] OP_PULSE_FUEL = 3'd4;
  localparam logic [2:0] OP_PULSE_HE   = 3'd5;
  localparam logic [2:0] OP_PULSE_OX   = 3'd6;

  // Error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_BURN_SHORT = 2'd1;
  localparam logic [1:0] ERR_LEAD_LONG  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_IGNITE = 1'b0;
  localparam logic CFG_PURGE  = 1'b1;

  // Valve channels
  localparam logic [2:0] CH_FUEL  = 3'd0;
  localparam logic [2:0] CH_OX    = 3'd1;
  localparam logic [2:0] CH_IGN   = 3'd2;
  localparam logic [2:0] CH_HE    = 3'd4;
  localparam logic [2:0] CH_PURGE = 3'd5;
  localparam logic [2:0] CH_OXB   = 3'd6;

  // Abort closes fuel, oxidizer, igniter, helium and the oxidizer bleed
  localparam logic [7:0] ABORT_MASK = 8'h57;

  localparam logic [15:0] IGNITE_MS_RST  = 16'd2800;
  localparam logic [19:0] PURGE_MS_RST   = 20'd30000;
  localparam logic [16:0] BURN_MARGIN_MS = 17'd200;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEAD   = 3'd1,
    PH_BURN   = 3'd2,
    PH_PURGE1 = 3'd3,
    PH_PURGE2 = 3'd4,
    PH_PULSE  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  valve_mask;
    logic [19:0] burn_ms;
    logic [19:0] lead_ms;
    logic [19:0] pulse_len_ms;
  } item_t;

  typedef struct packed {
    logic [7:0] valves;
    logic       busy_res;
    logic [1:0] error;
    phase_t     phase;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/vfs_in_stage.sv
`default_nettype none

module vfs_in_stage
  import vfs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire item_t in_item,
  input  wire logic  advance,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  take;

  // Room when empty or when the held beat moves on this cycle
  assign in_stall  = valid_r & ~advance;
  assign take      = in_valid & ~in_stall;
  assign valid_nxt = take | (valid_r & ~advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

FILE: rtl/core/vfs_seq_core.sv
`default_nettype none

module vfs_seq_core
  import vfs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [19:0] cfg_wdata,
  input  wire logic        step,
  input  wire item_t       item,
  output result_t          res_nxt
);

  typedef struct packed {
    logic [7:0]  valves;
    phase_t      phase;
    logic [19:0] ptimer;
    logic [15:0] itimer;
    logic        ign_live;
    logic [19:0] burn_len;
    logic [2:0]  pulse_chan;
  } seq_state_t;

  localparam int SETTLE_PASSES = 4;

  seq_state_t  st_r, st_nxt;
  logic [15:0] ignite_ms_r;
  logic [19:0] purge_ms_r;
  logic [1:0]  err;

  // One phase end: advance the sequence when the phase timer has run out
  function automatic seq_state_t settle_step(input seq_state_t s, input logic [15:0] ign,
                                             input logic [19:0] purge);
    seq_state_t n;
    n = s;
    if (s.phase != PH_IDLE && s.ptimer == '0) begin
      unique case (s.phase)
        PH_LEAD: begin
          n.valves[CH_OX]  = 1'b1;
          n.valves[CH_IGN] = (ign != '0);
          n.itimer         = ign;
          n.ign_live       = (ign != '0);
          n.phase          = PH_BURN;
          n.ptimer         = s.burn_len;
        end
        PH_BURN: begin
          n.valves[CH_OXB]   = 1'b0;
          n.valves[CH_PURGE] = 1'b1;
          n.phase            = PH_PURGE1;
          n.ptimer           = purge;
        end
        PH_PURGE1: begin
          n.valves[CH_HE] = 1'b0;
          n.phase         = PH_PURGE2;
          n.ptimer        = purge;
        end
        PH_PURGE2: begin
          n.valves[CH_PURGE] = 1'b0;
          n.valves[CH_OX]    = 1'b0;
          n.valves[CH_FUEL]  = 1'b0;
          n.phase            = PH_IDLE;
        end
        PH_PULSE: begin
          n.valves[s.pulse_chan] = 1'b0;
          n.phase                = PH_IDLE;
        end
        default: begin
          n.phase = PH_IDLE;
        end
      endcase
    end
    return n;
  endfunction

  always_comb begin
    seq_state_t  s;
    logic [16:0] burn_min;
    s        = st_r;
    err      = ERR_NONE;
    burn_min = {1'b0, ignite_ms_r} + BURN_MARGIN_MS;
    // Any real command other than a tick cancels the running sequence
    if (item.cmd != OP_TICK && item.cmd <= OP_PULSE_OX) begin
      s.phase    = PH_IDLE;
      s.ptimer   = '0;
      s.itimer   = '0;
      s.ign_live = 1'b0;
    end
    unique case (item.cmd)
      OP_TICK: begin
        if (s.phase != PH_IDLE) begin
          if (s.ign_live && s.itimer != '0) begin
            s.itimer = s.itimer - 16'd1;
          end
          if (s.ign_live && s.itimer == '0) begin
            s.valves[CH_IGN] = 1'b0;
            s.ign_live       = 1'b0;
          end
          if (s.ptimer != '0) begin
            s.ptimer = s.ptimer - 20'd1;
          end
        end
      end
      OP_SET: begin
        s.valves = item.valve_mask;
      end
      OP_FIRE: begin
        if (item.burn_ms < {3'd0, burn_min}) begin
          err = ERR_BURN_SHORT;
        end else if (item.lead_ms > {4'd0, ignite_ms_r}) begin
          err = ERR_LEAD_LONG;
        end else begin
          s.valves[CH_FUEL] = 1'b1;
          s.burn_len        = item.burn_ms;
          s.phase           = PH_LEAD;
          s.ptimer          = item.lead_ms;
        end
      end
      OP_ABORT: begin
        s.valves = s.valves & ~ABORT_MASK;
      end
      OP_PULSE_FUEL, OP_PULSE_HE, OP_PULSE_OX: begin
        if (item.cmd == OP_PULSE_FUEL) begin
          s.pulse_chan = CH_FUEL;
        end else if (item.cmd == OP_PULSE_HE) begin
          s.pulse_chan = CH_HE;
        end else begin
          s.pulse_chan = CH_OX;
        end
        s.valves[s.pulse_chan] = 1'b1;
        s.phase                = PH_PULSE;
        s.ptimer               = item.pulse_len_ms;
      end
      default: begin
      end
    endcase
    // Chain through every phase that ends right away
    for (int i = 0; i < SETTLE_PASSES; i++) begin
      s = settle_step(s, ignite_ms_r, purge_ms_r);
    end
    st_nxt = s;
  end

  assign res_nxt.valves   = st_nxt.valves;
  assign res_nxt.busy_res = (st_nxt.phase != PH_IDLE);
  assign res_nxt.error    = err;
  assign res_nxt.phase    = st_nxt.phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '{valves: '0, phase: PH_IDLE, ptimer: '0, itimer: '0,
                       ign_live: 1'b0, burn_len: '0, pulse_chan: '0};
      ignite_ms_r <= IGNITE_MS_RST;
      purge_ms_r  <= PURGE_MS_RST;
    end else begin
      if (step) begin
        st_r <= st_nxt;
      end
      if (cfg_we && cfg_idx == CFG_IGNITE) begin
        ignite_ms_r <= cfg_wdata[15:0];
      end
      if (cfg_we && cfg_idx == CFG_PURGE) begin
        purge_ms_r <= cfg_wdata;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_direct_set: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.cmd == OP_SET |=> st_r.valves == $past(item.valve_mask)
                                   && st_r.phase == PH_IDLE)
    else $error("direct set did not land on the valves");

  a_abort_closes: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.cmd == OP_ABORT |=> (st_r.valves & ABORT_MASK) == '0
                                     && st_r.phase == PH_IDLE)
    else $error("abort left a valve open or a sequence running");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.cmd == OP_TICK && st_r.phase == PH_IDLE |=> st_r == $past(st_r))
    else $error("tick while idle changed the sequencer state");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/vfs_out_stage.sv
`default_nettype none

module vfs_out_stage
  import vfs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t res_nxt,
  output logic         out_ready,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Accept a new beat when empty or when the held one leaves now
  assign out_ready = ~valid_r | ~out_stall;
  assign valid_nxt = load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

FILE: rtl/core/valve_firing_sequencer.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   in_cmd, in_valve_mask, in_burn_ms,
//                                            in_lead_ms, in_pulse_len_ms
// out       output     out_valid / out_stall out_valves, out_busy_res, out_error, out_phase
// cfg       input      cfg_we                cfg_idx, cfg_wdata
//
// One beat per cycle while out_stall is low; each beat yields exactly one result beat.
// A beat passes the input register, then the state update into the result register.
// The state update is combinational, with four chained phase-end steps at most.
// rst_n is synchronous, active low; it closes all valves and restores the timing registers.
// A stalled result holds; the input stalls only when the input register cannot move on.
`default_nettype none

module valve_firing_sequencer
  import vfs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [7:0]  in_valve_mask,
  input  wire logic [19:0] in_burn_ms,
  input  wire logic [19:0] in_lead_ms,
  input  wire logic [19:0] in_pulse_len_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_valves,
  output logic             out_busy_res,
  output logic [1:0]       out_error,
  output logic [2:0]       out_phase,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [19:0] cfg_wdata
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    out_ready;
  logic    advance;
  result_t res_nxt;
  result_t res;

  assign in_item.cmd          = in_cmd;
  assign in_item.valve_mask   = in_valve_mask;
  assign in_item.burn_ms      = in_burn_ms;
  assign in_item.lead_ms      = in_lead_ms;
  assign in_item.pulse_len_ms = in_pulse_len_ms;

  // Move the held beat through the state update whenever the result slot frees up
  assign advance = item_valid & out_ready;

  vfs_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  vfs_seq_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (item),
    .res_nxt   (res_nxt)
  );

  vfs_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_nxt   (res_nxt),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_valves   = res.valves;
  assign out_busy_res = res.busy_res;
  assign out_error    = res.error;
  assign out_phase    = res.phase;

`ifndef NO_ASSERTIONS
  a_error_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error != ERR_NONE |-> out_phase == PH_IDLE && !out_busy_res)
    else $error("rejected fire reported with a sequence running");

  a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_busy_res == (out_phase != PH_IDLE))
    else $error("busy flag disagrees with phase");
`endif

endmodule

`default_nettype wire
